// ----- rtl/rfa_pkg.sv -----
// Package for the reciprocal frequency averager.
// Holds payload and control types, command codes and register defaults.
// No dependencies; every rtl file imports it.
package rfa_pkg;

    localparam int TIMER_BITS_DEFAULT = 16;
    localparam int OVF_W              = 16;
    localparam int CAP_W              = 16;
    localparam int RATE_W             = 27;
    localparam int SAMP_W             = 8;
    localparam int SUM_W              = 35;
    localparam int CFG_IDX_W          = 2;

    localparam logic [1:0] CMD_START    = 2'd0;
    localparam logic [1:0] CMD_OVERFLOW = 2'd1;
    localparam logic [1:0] CMD_EDGE     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE    = 2'd1;

    localparam logic [SAMP_W-1:0] SAMPLES_RESET = 8'd11;
    localparam logic [RATE_W-1:0] RATE_RESET    = 27'd1000000;
    localparam logic [OVF_W-1:0]  OVF_MAX       = {OVF_W{1'b1}};

    typedef struct packed {
        logic [1:0]       cmd;
        logic [CAP_W-1:0] capture_value;
    } item_t;

    typedef struct packed {
        logic [RATE_W-1:0] frequency_mean;
        logic [SAMP_W-1:0] samples_used;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_FREQ,
        ST_DIV_MEAN,
        ST_WAIT_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic arm;
        logic ovf_inc;
        logic first_edge;
        logic div_freq;
        logic div_mean;
        logic accumulate;
        logic load_result;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic armed;
        logic first_pending;
        logic count_reached;
        logic div_done;
    } dp_status_t;

endpackage

// ----- rtl/rfa_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Uses rfa_pkg for the default dividend width; shared by frequency and mean divisions.
module rfa_div
    import rfa_pkg::*;
#(
    parameter int DVD_W = SUM_W,
    parameter int DVS_W = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CMP_W = (DVD_W + 1 > DVS_W) ? DVD_W + 1 : DVS_W;
    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVD_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;

    logic [DVD_W:0]   trial;
    logic [CMP_W:0]   diff;
    logic             fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        diff  = (CMP_W+1)'(trial) - (CMP_W+1)'(dvs_reg);
        fits  = ~diff[CMP_W];

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DVD_W-2:0], fits};
            rem_next = fits ? diff[DVD_W-1:0] : trial[DVD_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/rfa_datapath.sv -----
// Datapath: configuration registers, measurement state, period forming,
// shared divider and result register. Depends on rfa_pkg and rfa_div.
module rfa_datapath
    import rfa_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               dp_cmd,
    output dp_status_t            dp_status,
    input  logic [CAP_W-1:0]      capture_value,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [RATE_W-1:0]     cfg_data,
    output result_t               result
);

    localparam int PER_W = TIMER_BITS + OVF_W;
    localparam logic [PER_W-1:0] CAP_MASK = {{OVF_W{1'b0}}, {TIMER_BITS{1'b1}}};

    logic [SAMP_W-1:0] samples_reg;
    logic [RATE_W-1:0] rate_reg;
    logic              armed_reg, armed_next;
    logic              first_reg, first_next;
    logic [OVF_W-1:0]  ovf_reg, ovf_next;
    logic [SAMP_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    result_t           result_reg, result_next;

    logic [PER_W-1:0]  period_raw;
    logic [PER_W-1:0]  period;
    logic              div_start;
    logic [SUM_W-1:0]  div_dividend;
    logic [PER_W-1:0]  div_divisor;
    logic              div_done;
    logic [SUM_W-1:0]  div_quotient;

    always_comb
    begin
        period_raw = (PER_W'(capture_value) & CAP_MASK) + {ovf_reg, {TIMER_BITS{1'b0}}};
        // a zero period counts as one tick
        period = (period_raw == '0) ? PER_W'(1) : period_raw;

        div_start    = dp_cmd.div_freq | dp_cmd.div_mean;
        div_dividend = dp_cmd.div_mean ? sum_reg : SUM_W'(rate_reg);
        div_divisor  = dp_cmd.div_mean ? PER_W'(count_reg) : period;
    end

    rfa_div #(
        .DVD_W (SUM_W),
        .DVS_W (PER_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        armed_next  = armed_reg;
        first_next  = first_reg;
        ovf_next    = ovf_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        result_next = result_reg;

        if (dp_cmd.arm)
        begin
            armed_next = 1'b1;
            first_next = 1'b1;
            ovf_next   = '0;
            count_next = '0;
            sum_next   = '0;
        end
        if (dp_cmd.ovf_inc && ovf_reg != OVF_MAX)
        begin
            ovf_next = ovf_reg + 1'b1;
        end
        if (dp_cmd.first_edge)
        begin
            first_next = 1'b0;
            ovf_next   = '0;
        end
        if (dp_cmd.div_freq || dp_cmd.div_mean)
        begin
            // period is latched by the divider; the next period starts now
            ovf_next = '0;
        end
        if (dp_cmd.accumulate)
        begin
            sum_next   = sum_reg + div_quotient;
            count_next = count_reg + 1'b1;
        end
        if (dp_cmd.load_result)
        begin
            result_next.frequency_mean = (count_reg == '0) ? '0 : div_quotient[RATE_W-1:0];
            result_next.samples_used   = count_reg;
            armed_next = 1'b0;
            count_next = '0;
            sum_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_reg <= SAMPLES_RESET;
            rate_reg    <= RATE_RESET;
            armed_reg   <= 1'b0;
            first_reg   <= 1'b1;
            ovf_reg     <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_SAMPLES)
            begin
                samples_reg <= cfg_data[SAMP_W-1:0];
            end
            if (cfg_we && cfg_index == CFG_RATE)
            begin
                rate_reg <= cfg_data;
            end
            armed_reg <= armed_next;
            first_reg <= first_next;
            ovf_reg   <= ovf_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign dp_status.armed         = armed_reg;
    assign dp_status.first_pending = first_reg;
    assign dp_status.count_reached = (count_reg >= samples_reg);
    assign dp_status.div_done      = div_done;
    assign result                  = result_reg;

endmodule

// ----- rtl/rfa_ctrl.sv -----
// Controller: decodes accepted transactions, sequences the shared divider
// and owns the input stall and result valid. Depends on rfa_pkg.
module rfa_ctrl
    import rfa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [1:0] item_cmd,
    output logic       result_valid,
    input  logic       result_stall,
    output dp_cmd_t    dp_cmd,
    input  dp_status_t dp_status
);

    state_t state_reg, state_next;
    logic   rvalid_reg, rvalid_next;
    logic   slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        item_stall = 1'b1;
        slot_free  = ~rvalid_reg | ~result_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    unique case (item_cmd)
                        CMD_START:
                        begin
                            dp_cmd.arm = ~dp_status.armed;
                        end
                        CMD_OVERFLOW:
                        begin
                            dp_cmd.ovf_inc = dp_status.armed;
                        end
                        CMD_EDGE:
                        begin
                            if (dp_status.armed)
                            begin
                                if (dp_status.first_pending)
                                begin
                                    dp_cmd.first_edge = 1'b1;
                                end
                                else if (!dp_status.count_reached)
                                begin
                                    dp_cmd.div_freq = 1'b1;
                                    state_next      = ST_DIV_FREQ;
                                end
                                else
                                begin
                                    dp_cmd.div_mean = 1'b1;
                                    state_next      = ST_DIV_MEAN;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIV_FREQ:
            begin
                if (dp_status.div_done)
                begin
                    dp_cmd.accumulate = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            ST_DIV_MEAN:
            begin
                if (dp_status.div_done)
                begin
                    if (slot_free)
                    begin
                        dp_cmd.load_result = 1'b1;
                        state_next         = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_WAIT_OUT;
                    end
                end
            end
            ST_WAIT_OUT:
            begin
                // hold the quotient until the result register drains
                if (slot_free)
                begin
                    dp_cmd.load_result = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (dp_cmd.load_result)
        begin
            rvalid_next = 1'b1;
        end
        else if (rvalid_reg && !result_stall)
        begin
            rvalid_next = 1'b0;
        end
        else
        begin
            rvalid_next = rvalid_reg;
        end
    end

    assign result_valid = rvalid_reg;

endmodule

// ----- rtl/reciprocal_frequency_averager_core.sv -----
// Reciprocal frequency averager, top level.
// Item channel: item_valid/item_stall with item (cmd, capture_value).
// Result channel: result_valid/result_stall with result (frequency_mean,
// samples_used). Config channel: cfg_valid/cfg_ready, cfg_index, cfg_data;
// cfg_ready is always high, index 0 is the sample count, index 1 the
// reference tick rate.
// Start, overflow, first-edge and ignored transactions are accepted without a stall.
// A measuring edge runs one reference_rate / period division on the shared
// restoring divider, one quotient bit per cycle over 35 bits: the item
// channel stalls until the quotient has been added to the sum.
// The emitting edge divides the sum by the sample count the same way and
// result_valid rises once the mean is loaded into the result register.
// The result sits in an output register; new transactions are accepted while
// it waits. Only a further mean that finds the register still stalled holds
// the block (item_stall high) until the receiver takes the old result.
// Reset disarms the block, clears all measurement state, drops result_valid
// and loads sample count 11 and rate 1000000. Depends on rfa_pkg, rfa_ctrl
// and rfa_datapath.
module reciprocal_frequency_averager_core
    import rfa_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RATE_W-1:0]    cfg_data
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    rfa_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_cmd     (item.cmd),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .dp_cmd       (dp_cmd),
        .dp_status    (dp_status)
    );

    rfa_datapath #(
        .TIMER_BITS (TIMER_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .dp_cmd        (dp_cmd),
        .dp_status     (dp_status),
        .capture_value (item.capture_value),
        .cfg_we        (cfg_valid & cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result        (result)
    );

endmodule

// ----- rtl/rfa_checker.sv -----
// Port-level checker for the reciprocal frequency averager, bound to the top.
// Depends on rfa_pkg.
module rfa_checker
    import rfa_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 item_valid,
    input logic                 item_stall,
    input item_t                item,
    input logic                 result_valid,
    input logic                 result_stall,
    input result_t              result,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [RATE_W-1:0]    cfg_data
);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result changed while stalled");

    a_overflow_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.cmd == CMD_OVERFLOW && !result_valid
        |=> !result_valid)
        else $error("overflow transaction produced a result");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(item_stall) |-> $past(item_valid && !item_stall && item.cmd == CMD_EDGE))
        else $error("item channel stalled without an accepted edge");

endmodule

bind reciprocal_frequency_averager_core rfa_checker u_rfa_checker (.*);

// ----- bench/rfa_mean_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the reciprocal frequency averager: watches the item, result
// and register channels, predicts every mean and compares it on arrival.
// Depends on rfa_pkg only.
module rfa_mean_checker
    import rfa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 item_stall,
    input  item_t                item,
    input  logic                 result_valid,
    input  logic                 result_stall,
    input  result_t              result,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RATE_W-1:0]    cfg_data,
    output int                   fail_count,
    output int                   pending,
    output int                   means_checked,
    output int                   items_seen,
    output int                   reg_writes
);

    logic [SAMP_W-1:0] samples_cfg;
    logic [RATE_W-1:0] rate_cfg;

    logic              meter_armed;
    logic              await_first;
    logic [OVF_W-1:0]  ovf_ticks;
    logic [SAMP_W-1:0] taken;
    logic [SUM_W-1:0]  freq_total;

    result_t mean_queue[$];

    task automatic clear_meter();
        meter_armed = 1'b0;
        await_first = 1'b1;
        ovf_ticks   = '0;
        taken       = '0;
        freq_total  = '0;
    endtask

    // Advance the meter by one accepted transaction; queue a mean if one is due.
    task automatic advance_meter(input item_t it);
        logic [63:0]      period;
        logic [63:0]      quotient;
        logic [SUM_W-1:0] avg;
        result_t          mean_r;
        if (it.cmd == CMD_START) begin
            if (!meter_armed) begin
                clear_meter();
                meter_armed = 1'b1;
            end
        end else if (!meter_armed) begin
            // idle: drop overflows, edges and unknown codes
        end else if (it.cmd == CMD_OVERFLOW) begin
            if (ovf_ticks != OVF_MAX)
                ovf_ticks = ovf_ticks + 1'b1;
        end else if (it.cmd == CMD_EDGE) begin
            if (await_first) begin
                await_first = 1'b0;
                ovf_ticks   = '0;
            end else if (taken < samples_cfg) begin
                period = {48'd0, it.capture_value} + ({48'd0, ovf_ticks} << CAP_W);
                if (period == 64'd0)
                    period = 64'd1;
                quotient   = {37'd0, rate_cfg} / period;
                freq_total = freq_total + quotient[SUM_W-1:0];
                ovf_ticks  = '0;
                taken      = taken + 1'b1;
            end else begin
                avg = '0;
                if (taken != '0)
                    avg = freq_total / {{(SUM_W-SAMP_W){1'b0}}, taken};
                mean_r.frequency_mean = avg[RATE_W-1:0];
                mean_r.samples_used   = taken;
                mean_queue.push_back(mean_r);
                clear_meter();
            end
        end
    endtask

    always @(posedge clk) begin
        result_t want;
        if (!rst_n) begin
            samples_cfg   = SAMPLES_RESET;
            rate_cfg      = RATE_RESET;
            clear_meter();
            mean_queue.delete();
            fail_count    = 0;
            means_checked = 0;
            items_seen    = 0;
            reg_writes    = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                reg_writes++;
                if (cfg_index == CFG_SAMPLES)
                    samples_cfg = cfg_data[SAMP_W-1:0];
                else if (cfg_index == CFG_RATE)
                    rate_cfg = cfg_data;
            end
            if (item_valid && !item_stall) begin
                items_seen++;
                advance_meter(item);
            end
            if (result_valid && !result_stall) begin
                if (mean_queue.size() == 0) begin
                    $error("unexpected result: frequency_mean %0d samples_used %0d",
                           result.frequency_mean, result.samples_used);
                    fail_count++;
                end else begin
                    want = mean_queue.pop_front();
                    means_checked++;
                    if (result.frequency_mean !== want.frequency_mean) begin
                        $error("frequency_mean: expected %0d, actual %0d",
                               want.frequency_mean, result.frequency_mean);
                        fail_count++;
                    end
                    if (result.samples_used !== want.samples_used) begin
                        $error("samples_used: expected %0d, actual %0d",
                               want.samples_used, result.samples_used);
                        fail_count++;
                    end
                end
            end
        end
        pending = mean_queue.size();
    end

endmodule

// ----- bench/tb_reciprocal_frequency_averager_core.sv -----
`timescale 1ns / 1ps
// Testbench top for reciprocal_frequency_averager_core: clock, reset, stimulus
// and verdict. Checking is done by rfa_mean_checker; depends on rfa_pkg.
module tb_reciprocal_frequency_averager_core;
    import rfa_pkg::*;

    localparam logic [1:0]           CMD_RESERVED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B   = 2'd3;
    localparam logic [RATE_W-1:0]    RATE_MAX      = 27'd72000000;
    localparam int                   RANDOM_ITEMS  = 1380;
    localparam int                   SETTLE_CYCLES = 48;
    localparam int                   LONG_HOLD     = 900;
    localparam int                   LIMIT_CYCLES  = 1000000;

    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    item_t                item;
    logic                 result_valid;
    logic                 result_stall;
    result_t              result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [RATE_W-1:0]    cfg_data;

    int fail_count;
    int pending;
    int means_checked;
    int items_seen;
    int reg_writes;

    int items_sent = 0;
    int hold_len   = 0;
    bit burst      = 1'b0;

    reciprocal_frequency_averager_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    rfa_mean_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .item          (item),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .means_checked (means_checked),
        .items_seen    (items_seen),
        .reg_writes    (reg_writes)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // Receiver: after each taken result, hold stall for a drawn number of cycles.
    initial
    begin : receiver
        int stall_left;
        stall_left   = 0;
        result_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_len != 0)
            begin
                stall_left = hold_len;
                hold_len   = 0;
            end
            else if (result_valid && !result_stall)
                stall_left = burst ? 0 : $urandom_range(0, 7);
            else if (stall_left > 0)
                stall_left--;
            result_stall <= (stall_left != 0);
        end
    end

    function automatic logic [CAP_W-1:0] pick_capture();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return CAP_W'($urandom_range(1, 16));
            3:       return CAP_W'($urandom_range(1, 1000));
            default: return CAP_W'($urandom);
        endcase
    endfunction

    function automatic int pick_overflows();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return 0;
        if (roll < 9)
            return $urandom_range(1, 2);
        return $urandom_range(3, 8);
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 3))
            0:       return RATE_W'(1);
            1:       return RATE_MAX;
            2:       return RATE_RESET;
            default: return RATE_W'($urandom_range(1, 72000000));
        endcase
    endfunction

    task automatic send(input logic [1:0] code, input logic [CAP_W-1:0] cap);
        int    gap;
        item_t v;
        v.cmd           = code;
        v.capture_value = cap;
        gap = burst ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= v;
        do @(posedge clk); while (item_stall);
        items_sent++;
    endtask

    task automatic send_overflows(input int n);
        repeat (n) send(CMD_OVERFLOW, CAP_W'($urandom));
    endtask

    // Drop valid, wait for every mean to arrive, then let the divider settle.
    task automatic drain();
        item_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_config(input logic [SAMP_W-1:0] samples, input logic [RATE_W-1:0] rate);
        logic [RATE_W-1:0] word;
        // junk above the sample field must be dropped by the block
        word = RATE_W'($urandom);
        word[SAMP_W-1:0] = samples;
        write_reg(CFG_SAMPLES, word);
        write_reg(CFG_RATE, rate);
        cfg_valid <= 1'b0;
    endtask

    // One start-to-mean measurement; a cut one stops early and leaves the meter armed.
    task automatic run_measurement(input int samples, input bit cut);
        int stop_at;
        int i;
        stop_at = cut ? $urandom_range(0, samples) : samples;
        send(CMD_START, CAP_W'($urandom));
        send_overflows(pick_overflows());
        send(CMD_EDGE, CAP_W'($urandom));
        for (i = 0; i < stop_at; i++)
        begin
            send_overflows(pick_overflows());
            if ($urandom_range(0, 19) == 0)
                send(2'($urandom), CAP_W'($urandom));
            send(CMD_EDGE, pick_capture());
        end
        if (!cut)
        begin
            send_overflows(pick_overflows());
            send(CMD_EDGE, pick_capture());
        end
    endtask

    initial
    begin : stimulus
        int                phase;
        int                nseq;
        int                j;
        int                base_items;
        int                samples;
        logic [RATE_W-1:0] rate;

        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: ignored codes while idle, start while armed, zero period.
        send(CMD_EDGE, '1);
        send(CMD_OVERFLOW, '0);
        send(CMD_RESERVED, 16'hAAAA);
        send(CMD_START, '0);
        send(CMD_START, 16'h5555);
        send_overflows(2);
        send(CMD_EDGE, 16'h1234);
        send(CMD_EDGE, '0);
        send(CMD_EDGE, '1);
        send_overflows(2);
        send(CMD_EDGE, '0);
        send(CMD_RESERVED, '0);
        send(CMD_EDGE, 16'd1);
        send(CMD_EDGE, 16'h8000);
        send(CMD_EDGE, 16'h00FF);
        repeat (5) send(CMD_EDGE, pick_capture());
        send(CMD_EDGE, '1);
        drain();

        // Indexes past the register list must change nothing.
        write_reg(CFG_SPARE_A, RATE_W'(5));
        write_reg(CFG_SPARE_B, '1);
        cfg_valid <= 1'b0;

        // Zero samples: the first measuring edge emits an empty mean.
        set_config(8'd0, RATE_MAX);
        send(CMD_START, '0);
        send(CMD_EDGE, 16'h0F0F);
        send(CMD_EDGE, 16'hF0F0);
        drain();

        // Lower the sample count mid-measurement; the next edge emits.
        set_config(8'd3, RATE_MAX);
        send(CMD_START, '0);
        send(CMD_EDGE, '0);
        send(CMD_EDGE, 16'd1);
        send(CMD_EDGE, 16'h00F0);
        send(CMD_EDGE, '1);
        drain();
        write_reg(CFG_SAMPLES, RATE_W'(1));
        cfg_valid <= 1'b0;
        send(CMD_EDGE, 16'h4321);
        drain();

        base_items = items_sent;

        // Long receiver hold-off while means keep coming, so the input stalls.
        set_config(8'd1, pick_rate());
        hold_len = LONG_HOLD;
        burst    = 1'b1;
        repeat (4) run_measurement(1, 1'b0);
        burst = 1'b0;
        drain();

        phase = 0;
        while (items_sent - base_items < RANDOM_ITEMS)
        begin
            if (phase == 2)
                samples = 255;
            else if (phase % 7 == 5)
                samples = 0;
            else
                samples = $urandom_range(1, 6);
            rate  = pick_rate();
            burst = (phase % 5 == 4);
            set_config(SAMP_W'(samples), rate);
            nseq = (samples == 255) ? 1 : $urandom_range(2, 5);
            for (j = 0; j < nseq; j++)
                run_measurement(samples, ($urandom_range(0, 6) == 0));
            // noise between measurements, mostly dropped by an idle meter
            repeat ($urandom_range(0, 3)) send(2'($urandom), CAP_W'($urandom));
            burst = 1'b0;
            drain();
            phase++;
        end

        drain();
        $display("Covered %0d item transactions and %0d register writes; %0d means checked,",
                 items_seen, reg_writes, means_checked);
        $display("including overflow runs, zero periods, empty means and a stalled output.");
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
